### src/fqg_pkg.sv
// fqg_pkg: shared types, constants and register codes of the fingerprint quality grader
// used by every module under src but fqg_ram; depends on nothing
`default_nettype none

package fqg_pkg;

  // default geometry and resolution target
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned TARGET_PPI_DEF = 500;

  // configuration register file
  localparam int unsigned CFG_SIZE_W = 11;
  localparam int unsigned CFG_PPI_W  = 12;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_SCAN_PPI     = 2'd2
  } cfg_idx_e;

  localparam logic [CFG_SIZE_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_SIZE_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;
  localparam logic [CFG_PPI_W-1:0]  SCAN_PPI_RST     = 12'd500;

  // payload widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SCORE_W = 3;
  localparam int unsigned MAG2_W  = 17;  // gx^2 + gy^2 <= 2 * 255^2

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // square root of mag2 * 256: radicand below 2^25, top even bit 2^24
  localparam int unsigned SQ_W = 26;
  localparam logic [SQ_W-1:0] SQ_FIRST_BIT = 26'h100_0000;

  // clarity thresholds scaled by 16 (4 fraction bits)
  localparam logic [8:0] CLAR_GRADE1 = 9'd400;
  localparam logic [8:0] CLAR_GRADE2 = 9'd288;
  localparam logic [8:0] CLAR_GRADE3 = 9'd192;
  localparam logic [8:0] CLAR_GRADE4 = 9'd96;

  // deviation thresholds squared
  localparam logic [12:0] DEV_LOW  = 13'd900;
  localparam logic [12:0] DEV_HIGH = 13'd6400;
  localparam logic [12:0] DEV_MID  = 13'd400;

  // grades
  localparam logic [SCORE_W-1:0] SCORE_1 = 3'd1;
  localparam logic [SCORE_W-1:0] SCORE_2 = 3'd2;
  localparam logic [SCORE_W-1:0] SCORE_3 = 3'd3;
  localparam logic [SCORE_W-1:0] SCORE_4 = 3'd4;
  localparam logic [SCORE_W-1:0] SCORE_5 = 3'd5;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic              grad;
    logic [MAG2_W-1:0] mag2;
    logic              last;
  } fqg_cmd_t;

  // effective (clamped) geometry and resolution
  typedef struct packed {
    logic [CFG_SIZE_W-1:0] width;
    logic [CFG_SIZE_W-1:0] height;
    logic [CFG_PPI_W-1:0]  ppi;
  } fqg_cfg_t;

endpackage

`default_nettype wire

### src/fqg_ram.sv
// fqg_ram: generic single write port, single read port ram with registered read data
// standalone; no package needed
`default_nettype none

module fqg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/fqg_front.sv
// fqg_front: raster counters, two line stores and central-difference gradient per pixel
// depends on fqg_pkg and fqg_ram
`default_nettype none

module fqg_front #(
  parameter int unsigned MAX_WIDTH  = fqg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fqg_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       pix_valid_i,
  output logic                            pix_ready_o,
  input  wire logic [fqg_pkg::PIX_W-1:0]  pix_i,
  input  wire fqg_pkg::fqg_cfg_t          cfg_i,
  output logic                            cmd_valid_o,
  input  wire logic                       cmd_ready_i,
  output fqg_pkg::fqg_cmd_t               cmd_o
);
  import fqg_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned CMPW = 14;

  typedef enum logic [1:0] {F_IDLE, F_READ, F_WRITE} fstate_e;

  fstate_e          state_q;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [PIX_W-1:0] pix_q, prev_mid_q, mid_c_q, abv_c_q;

  logic             accept, wr_en, mid_re;
  logic [CW-1:0]    mid_raddr;
  logic [PIX_W-1:0] mid_rdata, abv_rdata;
  logic [CMPW-1:0]  col_ext, row_ext, w_ext, h_ext;
  logic             col_end, row_end, grad;
  logic signed [8:0]  gx, gy;
  logic signed [17:0] gx2, gy2;

  assign pix_ready_o = (state_q == F_IDLE);
  assign accept      = pix_valid_i && pix_ready_o;
  assign cmd_valid_o = (state_q == F_WRITE);
  assign wr_en       = cmd_valid_o && cmd_ready_i;
  assign mid_re      = accept || (state_q == F_READ);
  assign mid_raddr   = (state_q == F_READ) ? col_q + CW'(1) : col_q;

  fqg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(col_q),
    .wdata_i(pix_q),
    .re_i   (mid_re),
    .raddr_i(mid_raddr),
    .rdata_o(mid_rdata)
  );

  fqg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_abv_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(col_q),
    .wdata_i(mid_c_q),
    .re_i   (accept),
    .raddr_i(col_q),
    .rdata_o(abv_rdata)
  );

  always_comb begin
    col_ext = CMPW'(col_q);
    row_ext = CMPW'(row_q);
    w_ext   = CMPW'(cfg_i.width);
    h_ext   = CMPW'(cfg_i.height);
    col_end = (col_ext + CMPW'(1)) >= w_ext;
    row_end = (row_ext + CMPW'(1)) >= h_ext;
    grad    = (row_ext >= CMPW'(2)) && (col_q != '0) && ((col_ext + CMPW'(2)) <= w_ext);
    // mid_rdata holds the middle row at column + 1 here
    gx      = $signed({1'b0, mid_rdata}) - $signed({1'b0, prev_mid_q});
    gy      = $signed({1'b0, pix_q}) - $signed({1'b0, abv_c_q});
    gx2     = gx * gx;
    gy2     = gy * gy;
    cmd_o.pixel = pix_q;
    cmd_o.grad  = grad;
    cmd_o.mag2  = MAG2_W'($unsigned(gx2 + gy2));
    cmd_o.last  = col_end && row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      pix_q      <= '0;
      prev_mid_q <= '0;
      mid_c_q    <= '0;
      abv_c_q    <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (accept) begin
            pix_q   <= pix_i;
            state_q <= F_READ;
          end
        end
        F_READ: begin
          mid_c_q <= mid_rdata;
          abv_c_q <= abv_rdata;
          state_q <= F_WRITE;
        end
        F_WRITE: begin
          if (cmd_ready_i) begin
            prev_mid_q <= mid_c_q;
            if (col_end) begin
              col_q <= '0;
              row_q <= row_end ? '0 : row_q + RW'(1);
            end else begin
              col_q <= col_q + CW'(1);
            end
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/fqg_fifo.sv
// fqg_fifo: small register queue of classified pixels between front and back
// depends on fqg_pkg
`default_nettype none

module fqg_fifo #(
  parameter int unsigned DEPTH = fqg_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire fqg_pkg::fqg_cmd_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output fqg_pkg::fqg_cmd_t      pop_data_o
);
  import fqg_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  fqg_cmd_t      slot_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != NW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/fqg_back.sv
// fqg_back: square-root unit, frame accumulators and end-of-frame grading sequencer
// depends on fqg_pkg
`default_nettype none

module fqg_back #(
  parameter int unsigned MAX_WIDTH  = fqg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fqg_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned TARGET_PPI = fqg_pkg::TARGET_PPI_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cmd_valid_i,
  output logic                             cmd_ready_o,
  input  wire fqg_pkg::fqg_cmd_t           cmd_i,
  input  wire fqg_pkg::fqg_cfg_t           cfg_i,
  output logic                             score_valid_o,
  input  wire logic                        score_ready_i,
  output logic [fqg_pkg::SCORE_W-1:0]      score_o
);
  import fqg_pkg::*;

  localparam int unsigned NW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned PSW = NW + 8;
  localparam int unsigned PQW = NW + 16;
  localparam int unsigned GSW = NW + 14;
  localparam int unsigned PW  = 2 * NW + 16;
  localparam int unsigned MBW = (PSW > 13) ? PSW : 13;
  localparam int unsigned AREA_W = 2 * CFG_SIZE_W;

  typedef enum logic [2:0] {
    B_IDLE, B_SQRT, G_SIZE, G_SCALE, G_MUL_A, G_MUL_B, G_MUL_T, G_OUT
  } bstate_e;

  bstate_e          state_q;
  logic             last_q;
  logic [1:0]       sq_cnt_q;
  logic [SQ_W-1:0]  rem_q, res_q, bit_q;
  logic [PSW-1:0]   ps_q;
  logic [PQW-1:0]   pss_q;
  logic [GSW-1:0]   gs_q;
  logic [NW-1:0]    n_q, c_q;
  logic [2*NW-1:0]  nn_q;
  logic [3:0]       clar_q;
  logic [2:0]       dev_q;
  logic [1:0]       k_q;
  logic [PW-1:0]    acc_q, mc_q, a_q, d_q;
  logic [MBW-1:0]   mp_q;
  logic             ovalid_q;
  logic [SCORE_W-1:0] score_q;

  logic [SQ_W-1:0]  rem_n, res_n, bit_n;
  logic [PW-1:0]    acc_n;
  logic             mul_done, penalty, pop;
  logic [AREA_W-1:0] area, inner;
  logic [SCORE_W-1:0] grade;

  assign cmd_ready_o   = (state_q == B_IDLE);
  assign pop           = cmd_valid_i && cmd_ready_o;
  assign score_valid_o = ovalid_q;
  assign score_o       = score_q;

  // four restoring square-root steps per cycle
  always_comb begin
    rem_n = rem_q;
    res_n = res_q;
    bit_n = bit_q;
    for (int i = 0; i < 4; i++) begin
      if (bit_n != '0) begin
        if (rem_n >= res_n + bit_n) begin
          rem_n = rem_n - (res_n + bit_n);
          res_n = (res_n >> 1) + bit_n;
        end else begin
          res_n = res_n >> 1;
        end
      end
      bit_n = bit_n >> 2;
    end
  end

  // shift-add multiplier step
  assign mul_done = (mp_q == '0);
  assign acc_n    = mp_q[0] ? acc_q + mc_q : acc_q;

  always_comb begin
    area  = AREA_W'(cfg_i.width) * AREA_W'(cfg_i.height);
    inner = ((cfg_i.width >= CFG_SIZE_W'(3)) && (cfg_i.height >= CFG_SIZE_W'(3))) ?
            AREA_W'(cfg_i.width - CFG_SIZE_W'(2)) * AREA_W'(cfg_i.height - CFG_SIZE_W'(2)) :
            '0;
    penalty = (cfg_i.ppi != '0) &&
              (((32'(cfg_i.ppi) << 1) < 32'(TARGET_PPI)) ||
               (32'(cfg_i.ppi) > 32'(2 * TARGET_PPI)));
    if (clar_q[0] && dev_q[0] && dev_q[1]) begin
      grade = SCORE_1;
    end else if (clar_q[1] && dev_q[2]) begin
      grade = SCORE_2;
    end else if (clar_q[2]) begin
      grade = SCORE_3;
    end else if (clar_q[3]) begin
      grade = SCORE_4;
    end else begin
      grade = SCORE_5;
    end
    if (penalty && grade != SCORE_5) begin
      grade = grade + SCORE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      last_q   <= 1'b0;
      sq_cnt_q <= '0;
      rem_q    <= '0;
      res_q    <= '0;
      bit_q    <= '0;
      ps_q     <= '0;
      pss_q    <= '0;
      gs_q     <= '0;
      n_q      <= '0;
      c_q      <= '0;
      nn_q     <= '0;
      clar_q   <= '0;
      dev_q    <= '0;
      k_q      <= '0;
      acc_q    <= '0;
      mc_q     <= '0;
      mp_q     <= '0;
      a_q      <= '0;
      d_q      <= '0;
      ovalid_q <= 1'b0;
      score_q  <= '0;
    end else begin
      // in G_OUT the output register is handled by the sequencer below
      if (ovalid_q && score_ready_i && (state_q != G_OUT)) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop) begin
            ps_q   <= ps_q + PSW'(cmd_i.pixel);
            pss_q  <= pss_q + PQW'(16'(cmd_i.pixel) * 16'(cmd_i.pixel));
            last_q <= cmd_i.last;
            if (cmd_i.grad) begin
              rem_q    <= SQ_W'({cmd_i.mag2, 8'h00});
              res_q    <= '0;
              bit_q    <= SQ_FIRST_BIT;
              sq_cnt_q <= '0;
              state_q  <= B_SQRT;
            end else if (cmd_i.last) begin
              state_q <= G_SIZE;
            end
          end
        end
        B_SQRT: begin
          rem_q    <= rem_n;
          res_q    <= res_n;
          bit_q    <= bit_n;
          sq_cnt_q <= sq_cnt_q + 2'd1;
          if (sq_cnt_q == 2'd3) begin
            gs_q    <= gs_q + GSW'(res_n);
            state_q <= last_q ? G_SIZE : B_IDLE;
          end
        end
        G_SIZE: begin
          n_q     <= NW'(area);
          c_q     <= NW'(inner);
          state_q <= G_SCALE;
        end
        G_SCALE: begin
          nn_q      <= (2*NW)'(n_q) * (2*NW)'(n_q);
          clar_q[0] <= gs_q > GSW'(c_q) * GSW'(CLAR_GRADE1);
          clar_q[1] <= gs_q > GSW'(c_q) * GSW'(CLAR_GRADE2);
          clar_q[2] <= gs_q > GSW'(c_q) * GSW'(CLAR_GRADE3);
          clar_q[3] <= gs_q > GSW'(c_q) * GSW'(CLAR_GRADE4);
          acc_q     <= '0;
          mc_q      <= PW'(pss_q);
          mp_q      <= MBW'(n_q);
          state_q   <= G_MUL_A;
        end
        G_MUL_A: begin
          if (mul_done) begin
            a_q     <= acc_q;
            acc_q   <= '0;
            mc_q    <= PW'(ps_q);
            mp_q    <= MBW'(ps_q);
            state_q <= G_MUL_B;
          end else begin
            acc_q <= acc_n;
            mc_q  <= mc_q << 1;
            mp_q  <= mp_q >> 1;
          end
        end
        G_MUL_B: begin
          if (mul_done) begin
            d_q     <= (a_q > acc_q) ? a_q - acc_q : '0;
            acc_q   <= '0;
            mc_q    <= PW'(nn_q);
            mp_q    <= MBW'(DEV_LOW);
            k_q     <= '0;
            state_q <= G_MUL_T;
          end else begin
            acc_q <= acc_n;
            mc_q  <= mc_q << 1;
            mp_q  <= mp_q >> 1;
          end
        end
        G_MUL_T: begin
          if (mul_done) begin
            acc_q <= '0;
            mc_q  <= PW'(nn_q);
            k_q   <= k_q + 2'd1;
            case (k_q)
              2'd0: begin
                dev_q[0] <= d_q > acc_q;
                mp_q     <= MBW'(DEV_HIGH);
              end
              2'd1: begin
                dev_q[1] <= d_q < acc_q;
                mp_q     <= MBW'(DEV_MID);
              end
              default: begin
                dev_q[2] <= d_q > acc_q;
                state_q  <= G_OUT;
              end
            endcase
          end else begin
            acc_q <= acc_n;
            mc_q  <= mc_q << 1;
            mp_q  <= mp_q >> 1;
          end
        end
        G_OUT: begin
          if (!ovalid_q || score_ready_i) begin
            ovalid_q <= 1'b1;
            score_q  <= grade;
            ps_q     <= '0;
            pss_q    <= '0;
            gs_q     <= '0;
            state_q  <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/fingerprint_quality_grader.sv
// fingerprint_quality_grader: top level with configuration registers, front, queue and back
// depends on fqg_pkg, fqg_front, fqg_fifo, fqg_back
`default_nettype none

// Grades a grayscale fingerprint image streamed in raster order, one 8-bit pixel per
// transfer, and returns one grade (1 best .. 5 worst) after the last pixel of each frame.
// The front takes no new pixel until it has handed the last one on: the middle line store has
// one read port and is read twice (this column, next column) before both line stores are
// written back. Interior pixels pass in the back through a state that takes the transfer
// and a square-root unit that forms the gradient magnitude at 4 bits a cycle; border
// pixels skip the square-root unit, and a 4-entry queue lets the front run ahead meanwhile.
// At the end of a frame the back runs a shift-add multiplier for the exact deviation tests
// and then waits for the grade register to drain if it must; meanwhile the front can still
// fill the queue. Line stores need no clearing after reset. Write the size and resolution
// registers only while no frame is in flight.
module fingerprint_quality_grader #(
  parameter int unsigned MAX_WIDTH  = fqg_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = fqg_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned TARGET_PPI = fqg_pkg::TARGET_PPI_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // pixel stream
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [7:0]                     s_axis_tdata_i,   // [7:0] pixel
  // grade stream
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [7:0]                          m_axis_tdata_o,   // [2:0] quality_score
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [fqg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fqg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fqg_pkg::*;

  logic [CFG_SIZE_W-1:0] width_q, height_q;
  logic [CFG_PPI_W-1:0]  ppi_q;
  fqg_cfg_t              cfg_eff;

  fqg_cmd_t           f_cmd, q_cmd;
  logic               f_valid, f_ready, q_valid, q_ready;
  logic [SCORE_W-1:0] score;

  // register file is always ready; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_WIDTH_RST;
      height_q <= IMAGE_HEIGHT_RST;
      ppi_q    <= SCAN_PPI_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CFG_SIZE_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[CFG_SIZE_W-1:0];
        CFG_SCAN_PPI:     ppi_q    <= cfg_data_i[CFG_PPI_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_q == '0) begin
      cfg_eff.width = CFG_SIZE_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      cfg_eff.width = CFG_SIZE_W'(MAX_WIDTH);
    end else begin
      cfg_eff.width = width_q;
    end
    if (height_q == '0) begin
      cfg_eff.height = CFG_SIZE_W'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      cfg_eff.height = CFG_SIZE_W'(MAX_HEIGHT);
    end else begin
      cfg_eff.height = height_q;
    end
    cfg_eff.ppi = ppi_q;
  end

  // front: counters, line stores, gradient terms
  fqg_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_valid_i(s_axis_tvalid_i),
    .pix_ready_o(s_axis_tready_o),
    .pix_i      (s_axis_tdata_i),
    .cfg_i      (cfg_eff),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  // decoupling queue
  fqg_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_data_i (f_cmd),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_cmd)
  );

  // back: magnitude, sums, grading, output register
  fqg_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .TARGET_PPI(TARGET_PPI)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_ready),
    .cmd_i        (q_cmd),
    .cfg_i        (cfg_eff),
    .score_valid_o(m_axis_tvalid_o),
    .score_ready_i(m_axis_tready_i),
    .score_o      (score)
  );

  assign m_axis_tdata_o = {(8 - SCORE_W)'(0), score};

endmodule

`default_nettype wire

### src/fqg_checker.sv
// fqg_port_checks: port-level assertions for the fingerprint quality grader, bound to the top
// depends on fqg_pkg and fingerprint_quality_grader
`default_nettype none

module fqg_port_checks (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic [7:0]                     s_axis_tdata_i,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [7:0]                     m_axis_tdata_o,
  input wire logic                           cfg_valid_i,
  input wire logic                           cfg_ready_o,
  input wire logic [fqg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [fqg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import fqg_pkg::*;

  // a grade is always 1..5 with clear padding
  a_grade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] >= SCORE_1) && (m_axis_tdata_o[2:0] <= SCORE_5)
                        && (m_axis_tdata_o[7:3] == 5'd0))
    else $error("grade out of range");

  // a stalled grade holds
  a_grade_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled grade changed");

  // front is busy with line store access right after taking a pixel
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("pixel taken during line store access");

  // register file never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind fingerprint_quality_grader fqg_port_checks u_fqg_checker (.*);

`default_nettype wire

### test/fqg_checker.sv
// fqg_checker: watches the pixel, grade and configuration channels of the quality grader,
// predicts each frame grade and compares it with what the block returns; depends on fqg_pkg
`timescale 1ns / 100ps

module fqg_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  input  wire logic                           s_axis_tready_i,
  input  wire logic [7:0]                     s_axis_tdata_i,   // [7:0] pixel
  input  wire logic                           m_axis_tvalid_i,
  input  wire logic                           m_axis_tready_i,
  input  wire logic [7:0]                     m_axis_tdata_i,   // [2:0] quality_score
  input  wire logic                           cfg_valid_i,
  input  wire logic                           cfg_ready_i,
  input  wire logic [fqg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fqg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                  pending_o,
  output int                                  grades_seen_o,
  output int                                  fail_count_o
);
  import fqg_pkg::*;

  localparam int unsigned MAXW = MAX_WIDTH_DEF;
  localparam int unsigned MAXH = MAX_HEIGHT_DEF;

  logic [CFG_SIZE_W-1:0] width_reg, height_reg;
  logic [CFG_PPI_W-1:0]  ppi_reg;
  logic [7:0]            line_above [MAXW];
  logic [7:0]            line_mid   [MAXW];
  logic [7:0]            left_mid;
  int unsigned           col, row;
  longint unsigned       edge_acc, pix_sum, sq_sum;
  logic [SCORE_W-1:0]    grade_q [$];

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned root_floor(input int unsigned v);
    int unsigned r;
    int unsigned b;
    r = 0;
    b = 32'h4000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [SCORE_W-1:0] frame_grade(input int unsigned w, input int unsigned h);
    longint unsigned n, c, a, b, d, nn;
    logic [SCORE_W-1:0] s;
    n  = longint'(w) * h;
    c  = (w >= 3 && h >= 3) ? longint'(w - 2) * (h - 2) : 0;
    a  = n * sq_sum;
    b  = pix_sum * pix_sum;
    d  = (a > b) ? a - b : 0;
    nn = n * n;
    if (edge_acc > CLAR_GRADE1 * c && d > DEV_LOW * nn && d < DEV_HIGH * nn)
      s = SCORE_1;
    else if (edge_acc > CLAR_GRADE2 * c && d > DEV_MID * nn)
      s = SCORE_2;
    else if (edge_acc > CLAR_GRADE3 * c)
      s = SCORE_3;
    else if (edge_acc > CLAR_GRADE4 * c)
      s = SCORE_4;
    else
      s = SCORE_5;
    // resolution penalty
    if (ppi_reg != 0 && (2 * ppi_reg < TARGET_PPI_DEF || ppi_reg > 2 * TARGET_PPI_DEF)
        && s != SCORE_5)
      s = s + 1;
    return s;
  endfunction

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w, h, cc;
    int signed gx, gy;
    logic [7:0] p, old_mid;
    logic [SCORE_W-1:0] want;
    if (!rst_ni) begin
      width_reg = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      ppi_reg = SCAN_PPI_RST;
      left_mid = '0;
      col = 0;
      row = 0;
      edge_acc = 0;
      pix_sum = 0;
      sq_sum = 0;
      grade_q.delete();
      pending_o = 0;
      grades_seen_o = 0;
      fail_count_o = 0;
    end else begin
      // grade transfer: compare with the oldest open frame
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        grades_seen_o++;
        if (grade_q.size() == 0) begin
          report("unexpected grade", 8'hxx, m_axis_tdata_i);
        end else begin
          want = grade_q.pop_front();
          if (m_axis_tdata_i !== {5'b0, want}) report("quality_score", {5'b0, want},
                                                       m_axis_tdata_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data_i[CFG_SIZE_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data_i[CFG_SIZE_W-1:0];
          CFG_SCAN_PPI:     ppi_reg = cfg_data_i[CFG_PPI_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        w = clamp_size(width_reg, MAXW);
        h = clamp_size(height_reg, MAXH);
        p = s_axis_tdata_i;
        cc = (col >= MAXW) ? MAXW - 1 : col;
        // interior pixel: central differences from the two stored rows
        if (row >= 2 && cc >= 1 && cc + 2 <= w) begin
          gx = int'(line_mid[cc+1]) - int'(left_mid);
          gy = int'(p) - int'(line_above[cc]);
          edge_acc += root_floor((gx * gx + gy * gy) * 256);
        end
        pix_sum += p;
        sq_sum += longint'(p) * p;
        old_mid = line_mid[cc];
        line_above[cc] = old_mid;
        left_mid = old_mid;
        line_mid[cc] = p;
        if (col + 1 >= w) begin
          col = 0;
          if (row + 1 >= h) begin
            grade_q.push_back(frame_grade(w, h));
            row = 0;
            edge_acc = 0;
            pix_sum = 0;
            sq_sum = 0;
          end else begin
            row++;
          end
        end else begin
          col++;
        end
      end
      pending_o = grade_q.size();
    end
  end

endmodule

### test/tb_fingerprint_quality_grader.sv
// tb_fingerprint_quality_grader: stimulus and verdict for the fingerprint quality grader
// depends on fqg_pkg, fingerprint_quality_grader and fqg_checker
`timescale 1ns / 100ps

module tb_fingerprint_quality_grader;
  import fqg_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;  // cycles with no transfer at all
  localparam int unsigned HOLD_LEN   = 3000;   // long receiver hold-off
  localparam int unsigned SETTLE     = 300;    // back end finishing after the last grade
  localparam int unsigned PIXEL_GOAL = 350;

  logic clk, rst_n;
  logic s_valid, s_ready;
  logic [7:0] s_data;
  logic m_valid, m_ready;
  logic [7:0] m_data;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int pending, grades_seen, fail_count;
  int unsigned idle_cycles;
  int unsigned pixels_sent;
  bit no_gaps;       // burst mode of the sender
  bit hold_req;      // asks the receiver for its long hold-off
  bit hold_done;
  // sender's copy of the geometry, needed to size each frame
  int unsigned cur_w, cur_h;

  fingerprint_quality_grader u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),    // [7:0] pixel
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),    // [2:0] quality_score
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  fqg_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .grades_seen_o   (grades_seen),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // random gap: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned clamp_dim(input int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return v;
  endfunction

  // watchdog: no transfer on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[fingerprint_quality_grader] ERROR");
      $finish;
    end
  end

  // grade receiver with random stalls and one long hold-off
  initial begin
    int unsigned g;
    m_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        g = pick_gap();
        if (g == 0) begin
          m_ready <= 1'b1;
        end else begin
          m_ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) cur_w = clamp_dim(val[CFG_SIZE_W-1:0]);
    if (idx == CFG_IMAGE_HEIGHT) cur_h = clamp_dim(val[CFG_SIZE_W-1:0]);
  endtask

  // block idle: every grade back, then let the back end drain
  task automatic wait_idle();
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] ppi);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_SCAN_PPI, ppi);
  endtask

  // one frame; style picks the texture: noise, flat, low-amplitude noise, ramp, checkerboard
  task automatic send_frame(input int unsigned style, input int unsigned base,
                            input int unsigned amp);
    int unsigned x, y, v, g;
    for (y = 0; y < cur_h; y++) begin
      for (x = 0; x < cur_w; x++) begin
        case (style)
          0: v = $urandom_range(0, 255);
          1: v = base;
          2: v = base + $urandom_range(0, amp);
          3: v = base + x * amp / 4 + y;
          default: v = ((x + y) & 1) ? 255 : 0;
        endcase
        if (style == 3) v = v % 256;
        else if (v > 255) v = 255;
        @(negedge clk);
        s_valid <= 1'b1;
        s_data <= v[7:0];
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        pixels_sent++;
        g = no_gaps ? 0 : pick_gap();
        if (g != 0) begin
          @(negedge clk);
          s_valid <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
    @(negedge clk);
    s_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_size();
    int unsigned r;
    logic [CFG_SIZE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 8) v = 0;
    else if (r < 20) v = CFG_SIZE_W'($urandom_range(1, 2));
    else v = CFG_SIZE_W'($urandom_range(3, 10));
    // top data bit is not part of the size register
    return {1'($urandom_range(0, 1)), v};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_ppi();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 249;
      2: return 250;
      3: return 1000;
      4: return 1001;
      5: return 4095;
      default: return CFG_DATA_W'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    int unsigned k;
    s_valid = 1'b0;
    s_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    hold_req = 1'b0;
    no_gaps = 1'b0;
    pixels_sent = 0;
    cur_w = MAX_WIDTH_DEF;
    cur_h = MAX_HEIGHT_DEF;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero sizes act as one, single dark and bright pixels
    set_geometry(12'd0, 12'd0, 12'd500);
    send_frame(1, 0, 0);
    send_frame(1, 255, 0);
    // smallest frame with an interior pixel, strong edges, low resolution
    set_geometry(12'd3, 12'd3, 12'd249);
    send_frame(4, 0, 0);
    // flat frame, resolution at the top of the field
    set_geometry(12'd3, 12'd3, 12'd4095);
    send_frame(1, 128, 0);
    // tall single column, height above the max clamps
    set_geometry(12'd1, 12'd2047, 12'd250);
    send_frame(0, 0, 0);
    // ramps at the resolution limits
    set_geometry(12'd4, 12'd4, 12'd1000);
    send_frame(3, 10, 40);
    set_geometry(12'd4, 12'd4, 12'd1001);
    send_frame(3, 200, 90);
    // a two-wide frame has no interior
    set_geometry(12'd2, 12'd5, 12'd0);
    send_frame(0, 0, 0);

    // block fills up while the receiver holds off
    set_geometry(12'd4, 12'd4, 12'd500);
    hold_req = 1'b1;
    for (k = 0; k < 4; k++) send_frame(0, 0, 0);

    // random frames
    pixels_sent = 0;
    k = 0;
    while (pixels_sent < PIXEL_GOAL) begin
      if ($urandom_range(0, 2) == 0)
        set_geometry(rand_size(), rand_size(), rand_ppi());
      else if ($urandom_range(0, 7) == 0)
        wait (pending == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      send_frame($urandom_range(0, 4), $urandom_range(0, 255), $urandom_range(0, 255));
      k++;
    end
    no_gaps = 1'b0;

    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("[fingerprint_quality_grader] OK");
    end else begin
      $display("[fingerprint_quality_grader] ERROR");
    end
    $finish;
  end

endmodule

### fingerprint_quality_grader.f
src/fqg_pkg.sv
src/fqg_ram.sv
src/fqg_front.sv
src/fqg_fifo.sv
src/fqg_back.sv
src/fingerprint_quality_grader.sv
src/fqg_checker.sv
test/fqg_checker.sv
test/tb_fingerprint_quality_grader.sv
